[design/imu_bias_calibrate_correct_assert.svh]
// -----------------------------------------------------------------------------
// imu_bias_calibrate_correct_assert.svh
// Assertion macros used by the IMU bias calibration top-level design file.
// -----------------------------------------------------------------------------
`ifndef IMU_BIAS_CALIBRATE_CORRECT_ASSERT_SVH
`define IMU_BIAS_CALIBRATE_CORRECT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define IBCC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define IBCC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/ibcc_pkg.sv]
// -----------------------------------------------------------------------------
// ibcc_pkg
// Widths, codes and lane control type for the IMU bias calibration block.
// -----------------------------------------------------------------------------
package ibcc_pkg;

	localparam int AXES      = 6;
	localparam int ACC_AXES  = 3;
	localparam int RAW_W     = 16;
	localparam int SUM_W     = 24;
	localparam int SUM_MAG_W = 23;
	localparam int QUOT_W    = 16;
	localparam int OFF_W     = 18;
	localparam int GRAV_W    = 16;
	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 112;

	localparam int CAL_SAMPLES_DEF = 100;
	localparam logic [GRAV_W-1:0] GRAVITY_RESET = 16'd16384;
	// Gravity register value zero stands for a full 32768 counts
	localparam logic [OFF_W-1:0] GRAVITY_FULL = 18'd32768;

	typedef enum logic [1:0] {
		ST_ABSORB = 2'd0,
		ST_DONE   = 2'd1,
		ST_CORR   = 2'd2
	} status_t;

	typedef enum logic {
		REQ_MEAS = 1'b0,
		REQ_CAL  = 1'b1
	} req_t;

	typedef struct packed {
		logic cal_en;
		logic run_start;
		logic div_en;
		logic off_wr;
	} lane_ctrl_t;

endpackage

[design/imu_bias_calibrate_correct.sv]
// -----------------------------------------------------------------------------
// imu_bias_calibrate_correct
// Six-axis IMU bias calibration and correction.
//
// Channel   Dir  Signals                         Content
// s_*       in   s_tvalid/s_tready/s_tdata/tuser raw sample and request kind
// m_*       out  m_tvalid/m_tready/m_tdata/tuser corrected sample and status
// cfg_*     in   cfg_we/cfg_wdata                gravity counts register
//
// One sample is taken per clock while the output register can take it and
// no run is finishing. The last calibration sample of a run blocks the input
// through the finish sequence: first the per-lane reciprocal multiply that
// divides each sum by the run length, then the dominant-axis gravity removal
// in the merge stage that loads the offsets.
// Reset clears sums, offsets and the run count and sets gravity to 16384.
// A result waits in the output register while m_tready is low; input is
// taken only when that register is empty or being drained.
`include "imu_bias_calibrate_correct_assert.svh"

module imu_bias_calibrate_correct #(
	parameter int CAL_SAMPLES = ibcc_pkg::CAL_SAMPLES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
	input  logic [ibcc_pkg::S_TDATA_W-1:0]   s_tdata,
	// req_type
	input  logic [0:0]                       s_tuser,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// corr_accel_x, _y, _z, corr_gyro_x, _y, _z (18 bits each), 4 zero bits
	output logic [ibcc_pkg::M_TDATA_W-1:0]   m_tdata,
	// status
	output logic [1:0]                       m_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             cfg_we,
	input  logic [ibcc_pkg::GRAV_W-1:0]      cfg_wdata
);
	import ibcc_pkg::*;

	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

	logic [GRAV_W-1:0]       grav_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_next;
	logic                    run_end;
	logic                    fin_s1_q;
	logic                    fin_s2_q;
	logic                    in_xfer;
	logic                    is_cal;
	lane_ctrl_t              ctrl;
	logic [QUOT_W-1:0]       quot_mag [AXES];
	logic                    quot_neg [AXES];
	logic signed [OFF_W-1:0] off_new  [AXES];
	logic signed [OFF_W-1:0] corr     [AXES];
	logic [M_TDATA_W-1:0]    out_data;
	status_t                 out_status;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic [1:0]              m_tuser_q;

	// Handshake and lane control
	assign s_tready = (!m_tvalid_q || m_tready) && !fin_s1_q && !fin_s2_q;
	assign in_xfer  = s_tvalid && s_tready;
	assign is_cal   = (s_tuser[0] == REQ_CAL);

	assign count_next = count_q + CNT_W'(1);
	assign run_end    = (count_next == CNT_W'(CAL_SAMPLES));

	always_comb begin
		ctrl.cal_en    = in_xfer && is_cal;
		ctrl.run_start = (count_q == '0);
		ctrl.div_en    = fin_s1_q;
		ctrl.off_wr    = fin_s2_q;
	end

	// Gravity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAVITY_RESET;
		end else if (cfg_we) begin
			grav_q <= cfg_wdata;
		end
	end

	// Run count and finish sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			fin_s1_q <= 1'b0;
			fin_s2_q <= 1'b0;
		end else begin
			if (ctrl.cal_en) begin
				count_q <= run_end ? '0 : count_next;
			end
			fin_s1_q <= ctrl.cal_en && run_end;
			fin_s2_q <= fin_s1_q;
		end
	end

	// Axis lanes
	for (genvar k = 0; k < AXES; k++) begin : g_lane
		ibcc_lane #(
			.CAL_SAMPLES(CAL_SAMPLES)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.raw     ($signed(s_tdata[k*RAW_W +: RAW_W])),
			.off_new (off_new[k]),
			.quot_mag(quot_mag[k]),
			.quot_neg(quot_neg[k]),
			.corr    (corr[k])
		);
	end

	ibcc_merge u_merge (
		.quot_mag(quot_mag),
		.quot_neg(quot_neg),
		.grav    (grav_q),
		.off_new (off_new)
	);

	// Build the result; corrected fields only for measurements
	always_comb begin
		out_data = '0;
		if (is_cal) begin
			out_status = run_end ? ST_DONE : ST_ABSORB;
		end else begin
			out_status = ST_CORR;
			for (int k = 0; k < AXES; k++) begin
				out_data[k*OFF_W +: OFF_W] = corr[k];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_xfer) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_tdata_q <= out_data;
			m_tuser_q <= out_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`IBCC_ASSERT_NEVER(a_fin_overlap, clk, arst_n, fin_s1_q && fin_s2_q, "finish stages overlap")
	`IBCC_ASSERT(a_count_range, clk, arst_n, count_q < CNT_W'(CAL_SAMPLES), "run count out of range")
	`IBCC_ASSERT(a_done_status, clk, arst_n, (ctrl.cal_en && run_end) |=> (m_tvalid && m_tuser == ST_DONE && fin_s1_q), "run end not reported")
	`IBCC_ASSERT(a_meas_status, clk, arst_n, (in_xfer && !is_cal) |=> (m_tvalid && m_tuser == ST_CORR), "measurement status wrong")

endmodule

[design/ibcc_lane.sv]
// -----------------------------------------------------------------------------
// ibcc_lane
// One axis: running sum, divide by the run length, offset store and correction.
// -----------------------------------------------------------------------------
module ibcc_lane #(
	parameter int CAL_SAMPLES = ibcc_pkg::CAL_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ibcc_pkg::lane_ctrl_t                ctrl,
	input  logic signed [ibcc_pkg::RAW_W-1:0]   raw,
	input  logic signed [ibcc_pkg::OFF_W-1:0]   off_new,
	output logic        [ibcc_pkg::QUOT_W-1:0]  quot_mag,
	output logic                                quot_neg,
	output logic signed [ibcc_pkg::OFF_W-1:0]   corr
);
	import ibcc_pkg::*;

	// Reciprocal for an exact floor divide of a SUM_MAG_W-bit magnitude
	localparam int     RECIP_SHIFT = SUM_MAG_W + $clog2(CAL_SAMPLES);
	localparam int     RECIP_W     = SUM_MAG_W + 1;
	localparam int     PROD_W      = SUM_MAG_W + RECIP_W;
	localparam longint RECIP       =
		((longint'(1) << RECIP_SHIFT) + longint'(CAL_SAMPLES) - 1) / CAL_SAMPLES;

	logic signed [SUM_W-1:0]     sum_q;
	logic signed [SUM_W-1:0]     sum_base;
	logic signed [SUM_W-1:0]     sum_next;
	logic        [SUM_MAG_W-1:0] sum_abs;
	logic        [PROD_W-1:0]    prod;
	logic        [RECIP_W-1:0]   recip_c;
	logic        [QUOT_W-1:0]    quot_mag_s2;
	logic                        quot_neg_s2;
	logic signed [OFF_W-1:0]     off_q;

	// Accumulate, clearing at the first sample of a run
	always_comb begin
		sum_base = ctrl.run_start ? '0 : sum_q;
		sum_next = sum_base + SUM_W'(raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.cal_en) begin
			sum_q <= sum_next;
		end
	end

	// Divide magnitude by the run length, truncating toward zero
	always_comb begin
		recip_c = RECIP_W'(RECIP);
		sum_abs = sum_q[SUM_W-1] ? SUM_MAG_W'(-sum_q) : SUM_MAG_W'(sum_q);
		prod    = PROD_W'(sum_abs) * PROD_W'(recip_c);
	end

	always_ff @(posedge clk) begin
		if (ctrl.div_en) begin
			quot_mag_s2 <= prod[RECIP_SHIFT +: QUOT_W];
			quot_neg_s2 <= sum_q[SUM_W-1];
		end
	end

	assign quot_mag = quot_mag_s2;
	assign quot_neg = quot_neg_s2;

	// Hold the offset; load it when the merge stage finishes a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (ctrl.off_wr) begin
			off_q <= off_new;
		end
	end

	assign corr = OFF_W'(raw) - off_q;

endmodule

[design/ibcc_merge.sv]
// -----------------------------------------------------------------------------
// ibcc_merge
// Combines lane quotients: signs them and removes gravity from the dominant
// accelerometer axis.
// -----------------------------------------------------------------------------
module ibcc_merge (
	input  logic        [ibcc_pkg::QUOT_W-1:0] quot_mag [ibcc_pkg::AXES],
	input  logic                               quot_neg [ibcc_pkg::AXES],
	input  logic        [ibcc_pkg::GRAV_W-1:0] grav,
	output logic signed [ibcc_pkg::OFF_W-1:0]  off_new  [ibcc_pkg::AXES]
);
	import ibcc_pkg::*;

	logic signed [OFF_W-1:0] quot [AXES];
	logic signed [OFF_W-1:0] g_val;
	logic signed [OFF_W-1:0] q_dom;
	logic signed [OFF_W-1:0] adj;
	logic        [1:0]       dom_idx;
	logic                    dom_pos;

	always_comb begin
		// Apply the sign to each quotient
		for (int k = 0; k < AXES; k++) begin
			quot[k] = quot_neg[k] ? -OFF_W'(quot_mag[k]) : OFF_W'(quot_mag[k]);
		end

		// Largest accelerometer magnitude, lower index wins a tie
		dom_idx = 2'd0;
		if (quot_mag[1] > quot_mag[0]) begin
			dom_idx = 2'd1;
		end
		if (quot_mag[2] > quot_mag[{1'b0, dom_idx}]) begin
			dom_idx = 2'd2;
		end

		// Remove one g from the dominant axis: subtract it from a positive quotient, else add it
		g_val   = (grav == '0) ? GRAVITY_FULL : OFF_W'(grav);
		q_dom   = quot[{1'b0, dom_idx}];
		dom_pos = !quot_neg[{1'b0, dom_idx}] && (quot_mag[{1'b0, dom_idx}] != '0);
		adj     = dom_pos ? (q_dom - g_val) : (q_dom + g_val);

		for (int k = 0; k < AXES; k++) begin
			off_new[k] = quot[k];
		end
		for (int k = 0; k < ACC_AXES; k++) begin
			if (2'(k) == dom_idx) begin
				off_new[k] = adj;
			end
		end
	end

endmodule

[test/tb_top.sv]
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the six-axis IMU bias calibration block.
//
// Calibration runs of different shapes go in: sensor at rest with gravity on
// one axis, saturated highs and lows, equal magnitudes on the accelerometer
// axes, all zeros, and pure noise. Measurement samples are mixed into and
// between those runs. A bias predictor in the scoreboard keeps its own sums,
// offsets and run count and works out each expected status and corrected
// sample. Every returned transfer is checked field by field. The gravity
// register is rewritten between phases, and the phases vary the input gaps
// and output back-pressure.
// -----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ibcc_pkg::*;

	localparam int CAL_RUN         = 100;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int PHASES          = 7;
	// Closing a run keeps the block busy after the done status while the offsets are computed and loaded
	localparam int SETTLE_CYCLES   = 4;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum int {PROF_REST, PROF_MAX, PROF_MIN, PROF_TIE, PROF_ZERO, PROF_WILD} run_profile_t;

	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z from the lowest bits up
	typedef logic [AXES-1:0][RAW_W-1:0] sample_t;

	typedef struct packed {
		status_t                    status;
		logic [AXES-1:0][OFF_W-1:0] corr;
	} bias_result_t;

	logic                   clk;
	logic                   arst_n;
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
	logic [S_TDATA_W-1:0]   s_tdata;
	// req_type
	logic [0:0]             s_tuser;
	logic                   s_tvalid;
	logic                   s_tready;
	// corr_accel_x, _y, _z, corr_gyro_x, _y, _z (18 bits each), 4 zero bits
	logic [M_TDATA_W-1:0]   m_tdata;
	// status
	logic [1:0]             m_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_we;
	logic [GRAV_W-1:0]      cfg_wdata;

	idle_mode_t             idle_mode = IDLE_NONE;
	int                     items_sent;

	// Calibration run being generated
	int                     cal_left;
	run_profile_t           profile;
	int                     run_base [AXES];
	int                     noise;

	imu_bias_calibrate_correct #(.CAL_SAMPLES(CAL_RUN)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Bias predictor and queue of outstanding corrected samples
	class bias_scoreboard;
		logic [GRAV_W-1:0]       gravity;
		logic signed [SUM_W-1:0] sums [AXES];
		int                      offsets [AXES];
		int                      run_count;
		bias_result_t            result_q [$];
		int                      errors;
		int                      checked;
		int                      runs_done;
		int                      corrections;

		function new();
			gravity = GRAVITY_RESET;
			foreach (sums[k]) begin
				sums[k] = '0;
				offsets[k] = 0;
			end
			run_count = 0;
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		// Turn the sums into offsets and pull gravity out of the dominant accel axis
		function void close_run();
			int g;
			int dom;
			g = (gravity == '0) ? 32768 : int'(gravity);
			for (int k = 0; k < AXES; k++)
				offsets[k] = int'(sums[k]) / CAL_RUN;
			dom = 0;
			for (int k = 1; k < ACC_AXES; k++)
				if (magnitude(offsets[k]) > magnitude(offsets[dom]))
					dom = k;
			if (offsets[dom] > 0)
				offsets[dom] -= g;
			else
				offsets[dom] += g;
		endfunction

		function void note_sample(req_t req, sample_t raw);
			bias_result_t res;
			logic signed [RAW_W-1:0] r;
			int d;
			res = '0;
			if (req == REQ_CAL) begin
				// A new run starts from cleared sums
				if (run_count == 0)
					foreach (sums[k]) sums[k] = '0;
				for (int k = 0; k < AXES; k++) begin
					r = raw[k];
					sums[k] = sums[k] + r;
				end
				run_count++;
				if (run_count >= CAL_RUN) begin
					close_run();
					run_count = 0;
					runs_done++;
					res.status = ST_DONE;
				end else begin
					res.status = ST_ABSORB;
				end
			end else begin
				res.status = ST_CORR;
				for (int k = 0; k < AXES; k++) begin
					r = raw[k];
					d = r - offsets[k];
					res.corr[k] = d[OFF_W-1:0];
				end
				corrections++;
			end
			result_q.push_back(res);
		endfunction

		function void check_result(logic [1:0] status, logic [M_TDATA_W-1:0] data);
			bias_result_t want;
			logic [AXES-1:0][OFF_W-1:0] got;
			got = data[AXES*OFF_W-1:0];
			if (result_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, status %0d data %h", $time, status, data);
			end else begin
				want = result_q.pop_front();
				checked++;
				if (status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				end
				for (int k = 0; k < AXES; k++)
					if (got[k] !== want.corr[k]) begin
						errors++;
						$display("%0t: axis %0d expected %0d actual %0d", $time, k,
							$signed(want.corr[k]), $signed(got[k]));
					end
				if (data[M_TDATA_W-1:AXES*OFF_W] !== '0) begin
					errors++;
					$display("%0t: pad bits expected 0 actual %h", $time,
						data[M_TDATA_W-1:AXES*OFF_W]);
				end
			end
		endfunction
	endclass

	bias_scoreboard board;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Check each result transfer, then pick the next ready level
	always @(posedge clk) begin : drain_side
		int stall_pct;
		if (m_tvalid && m_tready)
			board.check_result(m_tuser, m_tdata);
		stall_pct = (idle_mode == IDLE_RECV) ? 83 : (idle_mode == IDLE_BOTH) ? 35 : 0;
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Offer one sample after a random gap and hold it until it is taken
	task automatic send_sample(req_t req, sample_t raw);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SEND) ? 83 : (idle_mode == IDLE_BOTH) ? 35 : 0;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom, $urandom};
			s_tuser  <= 1'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
		board.note_sample(req, raw);
		items_sent++;
	endtask

	// Hold the input until every outstanding result is back and the block settles
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gravity(logic [GRAV_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		board.gravity = value;
		cfg_we    <= 1'b0;
	endtask

	// Pick the shape of a new calibration run
	function automatic void start_run();
		int pick;
		int dom;
		int v;
		cal_left = CAL_RUN;
		pick = $urandom_range(9);
		noise = 0;
		case (pick)
			5: profile = PROF_MAX;
			6: profile = PROF_MIN;
			7: profile = PROF_TIE;
			8: profile = PROF_ZERO;
			9: profile = PROF_WILD;
			default: profile = PROF_REST;
		endcase
		case (profile)
			PROF_REST: begin
				// Small bias everywhere, one accel axis carrying gravity
				noise = 64;
				foreach (run_base[k])
					run_base[k] = int'($urandom_range(1200)) - 600;
				dom = $urandom_range(ACC_AXES - 1);
				v = $urandom_range(4000, 20000);
				run_base[dom] = $urandom_range(1) ? v : -v;
			end
			PROF_MAX: foreach (run_base[k]) run_base[k] = 32767;
			PROF_MIN: foreach (run_base[k]) run_base[k] = -32768;
			PROF_TIE: begin
				// Equal magnitudes on the accel axes, sometimes axis X smaller
				v = $urandom_range(32767);
				for (int k = 0; k < ACC_AXES; k++)
					run_base[k] = $urandom_range(1) ? v : -v;
				if ($urandom_range(1))
					run_base[0] = run_base[0] / 2;
				for (int k = ACC_AXES; k < AXES; k++)
					run_base[k] = int'($urandom_range(200)) - 100;
			end
			default: foreach (run_base[k]) run_base[k] = 0;
		endcase
	endfunction

	function automatic sample_t run_sample();
		sample_t s;
		int v;
		for (int k = 0; k < AXES; k++) begin
			if (profile == PROF_WILD) begin
				s[k] = RAW_W'($urandom);
			end else begin
				v = run_base[k] + int'($urandom_range(2 * noise)) - noise;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				s[k] = v[RAW_W-1:0];
			end
		end
		return s;
	endfunction

	function automatic sample_t wild_sample();
		sample_t s;
		for (int k = 0; k < AXES; k++)
			case ($urandom_range(7))
				0: s[k] = 16'h7FFF;
				1: s[k] = 16'h8000;
				default: s[k] = RAW_W'($urandom);
			endcase
		return s;
	endfunction

	initial begin
		logic [GRAV_W-1:0] grav_plan [PHASES];
		idle_mode_t mode_plan [PHASES];
		grav_plan = '{16'd16384, 16'd1, 16'd0, 16'h8000, 16'hFFFF, 16'd0, 16'd16384};
		mode_plan = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH,
			IDLE_SEND};
		board = new();
		items_sent = 0;
		cal_left = 0;
		profile = PROF_ZERO;
		noise = 0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes against the zero offsets left by reset
		send_sample(REQ_MEAS, {AXES{16'h7FFF}});
		send_sample(REQ_MEAS, {AXES{16'h8000}});
		send_sample(REQ_MEAS, {AXES{16'h0000}});
		send_sample(REQ_MEAS, {AXES{16'hFFFF}});
		send_sample(REQ_MEAS, {AXES{16'h5555}});
		send_sample(REQ_MEAS, {AXES{16'hAAAA}});

		// Calibration runs with measurements mixed in, one gravity setting per phase
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p > 0)
				write_gravity((p == 5) ? GRAV_W'($urandom) : grav_plan[p]);
			idle_mode = mode_plan[p];
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (cal_left == 0 && $urandom_range(99) < 70)
					start_run();
				if (cal_left > 0 && $urandom_range(99) < 85) begin
					send_sample(REQ_CAL, run_sample());
					cal_left--;
				end else begin
					send_sample(REQ_MEAS, wild_sample());
				end
				// Now and then let the output side empty out mid-run
				if ($urandom_range(199) == 0)
					wait_drained();
			end
		end
		wait_drained();

		$display("Sent %0d samples over %0d gravity settings and four idle patterns;",
			items_sent, PHASES);
		$display("checked %0d transfers: %0d closed calibration runs, %0d corrections.",
			board.checked, board.runs_done, board.corrections);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("Timeout with %0d results outstanding", board.result_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
